[src/mf3_pkg.sv]
// Shared types and constants for the 3x3 median filter.
package mf3_pkg;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 10;
    localparam int SIZE_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int WIN_N     = 9;
    localparam int MIN_SIZE  = 3;

    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [SIZE_W-1:0]  size_t;
    typedef pix_t [WIN_N-1:0]   window_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } cfg_idx_t;

    localparam size_t RESET_WIDTH  = 11'd640;
    localparam size_t RESET_HEIGHT = 11'd480;

endpackage

[src/mf3_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mf3_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/mf3_median9.sv]
// Median of a 3x3 window: sort rows, then median of max-low, mid-mid, min-high.
module mf3_median9 (
    input  mf3_pkg::window_t win,
    output mf3_pkg::pix_t    median
);

    function automatic mf3_pkg::pix_t min2(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic mf3_pkg::pix_t max2(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic mf3_pkg::pix_t med3(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b,
                                           input mf3_pkg::pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    mf3_pkg::pix_t row_lo [3];
    mf3_pkg::pix_t row_md [3];
    mf3_pkg::pix_t row_hi [3];
    mf3_pkg::pix_t lo_max;
    mf3_pkg::pix_t md_med;
    mf3_pkg::pix_t hi_min;

    always_comb begin
        for (int n = 0; n < 3; n++) begin
            row_lo[n] = min2(min2(win[n*3+0], win[n*3+1]), win[n*3+2]);
            row_hi[n] = max2(max2(win[n*3+0], win[n*3+1]), win[n*3+2]);
            row_md[n] = med3(win[n*3+0], win[n*3+1], win[n*3+2]);
        end
        lo_max = max2(max2(row_lo[0], row_lo[1]), row_lo[2]);
        hi_min = min2(min2(row_hi[0], row_hi[1]), row_hi[2]);
        md_med = med3(row_md[0], row_md[1], row_md[2]);
        median = med3(lo_max, md_med, hi_min);
    end

endmodule

[src/median_filter_3x3_core.sv]
// Streaming 3x3 median filter top level: counters, line stores, window, output stage.
// Throughput: one pixel per cycle unless m_ready back-pressure stalls the pipeline.
// The line-store read (registered RAM port) sets the first stage; the window shift and
// the median network each take one more register stage.
// Reset (aresetn, synchronous, active low): counters and window cleared, width 640,
// height 480; line stores are not cleared and hold no data until written.
module median_filter_3x3_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  mf3_pkg::size_t                    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  mf3_pkg::pix_t                     s_pixel_in,
    input  logic                              s_frame_start,
    output logic                              m_valid,
    input  logic                              m_ready,
    output mf3_pkg::pix_t                     m_median_value,
    output mf3_pkg::coord_t                   m_center_row,
    output mf3_pkg::coord_t                   m_center_col
);

    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int RIW = $clog2(MAX_HEIGHT + 1);

    // configuration
    mf3_pkg::size_t width_reg;
    mf3_pkg::size_t height_reg;
    logic [31:0]    width_ext;
    logic [31:0]    height_ext;
    logic [CW-1:0]  width_eff;
    logic [RIW-1:0] height_eff;

    // frame counters
    logic [CW-1:0]  col_reg;
    logic [CW-1:0]  col_next;
    logic [RW-1:0]  row_reg;
    logic [RW-1:0]  row_next;
    logic [RIW-1:0] row_inc;
    logic [RIW-1:0] row_cand;
    logic [CW-1:0]  col_cur;
    logic [CW-1:0]  col_m1;
    logic [RW-1:0]  row_m1;
    logic           emit_cur;
    logic           s_accept;

    // stage 1: line-store read in flight
    logic            v1_reg;
    mf3_pkg::pix_t   px1_reg;
    logic [AW-1:0]   addr1_reg;
    logic            emit1_reg;
    mf3_pkg::coord_t orow1_reg;
    mf3_pkg::coord_t ocol1_reg;
    logic            byp1_reg;
    mf3_pkg::pix_t   bup1_reg;
    mf3_pkg::pix_t   bmid1_reg;
    logic            byp_next;
    mf3_pkg::pix_t   up_q;
    mf3_pkg::pix_t   mid_q;
    mf3_pkg::pix_t   up1;
    mf3_pkg::pix_t   mid1;
    logic            adv1;

    // stage 2: window
    mf3_pkg::window_t win_reg;
    logic             pend_reg;
    mf3_pkg::coord_t  orow2_reg;
    mf3_pkg::coord_t  ocol2_reg;
    logic             adv2;
    mf3_pkg::pix_t    median;

    // output stage
    logic            m_valid_reg;
    mf3_pkg::pix_t   m_median_reg;
    mf3_pkg::coord_t m_row_reg;
    mf3_pkg::coord_t m_col_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= mf3_pkg::RESET_WIDTH;
            height_reg <= mf3_pkg::RESET_HEIGHT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mf3_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                mf3_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturate sizes to [3, MAX]
    always_comb begin
        width_ext  = 32'(width_reg);
        height_ext = 32'(height_reg);
        if (width_ext < 32'(mf3_pkg::MIN_SIZE)) begin
            width_eff = CW'(mf3_pkg::MIN_SIZE);
        end else if (width_ext > 32'(MAX_WIDTH)) begin
            width_eff = CW'(MAX_WIDTH);
        end else begin
            width_eff = CW'(width_ext);
        end
        if (height_ext < 32'(mf3_pkg::MIN_SIZE)) begin
            height_eff = RIW'(mf3_pkg::MIN_SIZE);
        end else if (height_ext > 32'(MAX_HEIGHT)) begin
            height_eff = RIW'(MAX_HEIGHT);
        end else begin
            height_eff = RIW'(height_ext);
        end
    end

    // position of the incoming pixel
    always_comb begin
        row_inc = RIW'(row_reg) + RIW'(1);
        if (s_frame_start) begin
            col_cur  = '0;
            row_cand = '0;
        end else if (col_reg >= width_eff) begin
            col_cur  = '0;
            row_cand = row_inc;
        end else begin
            col_cur  = col_reg;
            row_cand = RIW'(row_reg);
        end
        row_next = (row_cand >= height_eff) ? '0 : RW'(row_cand);
        col_next = col_cur + CW'(1);
        emit_cur = (row_next >= RW'(2)) && (col_cur >= CW'(2));
        row_m1   = row_next - RW'(1);
        col_m1   = col_cur - CW'(1);
    end

    assign adv2     = pend_reg && (!m_valid_reg || m_ready);
    assign adv1     = v1_reg && (!pend_reg || adv2);
    assign s_ready  = !v1_reg || adv1;
    assign s_accept = s_valid && s_ready;

    // the previous pixel writes the same column this cycle: forward its data
    assign byp_next = adv1 && (addr1_reg == col_cur[AW-1:0]);
    assign up1      = byp1_reg ? bup1_reg : up_q;
    assign mid1     = byp1_reg ? bmid1_reg : mid_q;

    mf3_ram #(
        .DATA_W (mf3_pkg::PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_upper (
        .aclk    (aclk),
        .wr_en   (adv1),
        .wr_addr (addr1_reg),
        .wr_data (mid1),
        .rd_en   (s_accept),
        .rd_addr (col_cur[AW-1:0]),
        .rd_data (up_q)
    );

    mf3_ram #(
        .DATA_W (mf3_pkg::PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_middle (
        .aclk    (aclk),
        .wr_en   (adv1),
        .wr_addr (addr1_reg),
        .wr_data (px1_reg),
        .rd_en   (s_accept),
        .rd_addr (col_cur[AW-1:0]),
        .rd_data (mid_q)
    );

    mf3_median9 u_median (
        .win    (win_reg),
        .median (median)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            v1_reg      <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            win_reg     <= '0;
        end else begin
            if (s_accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
                v1_reg  <= 1'b1;
            end else if (adv1) begin
                v1_reg <= 1'b0;
            end
            if (adv1) begin
                pend_reg <= emit1_reg;
                for (int n = 0; n < 3; n++) begin
                    win_reg[n*3+0] <= win_reg[n*3+1];
                    win_reg[n*3+1] <= win_reg[n*3+2];
                end
                win_reg[2] <= up1;
                win_reg[5] <= mid1;
                win_reg[8] <= px1_reg;
            end else if (adv2) begin
                pend_reg <= 1'b0;
            end
            if (adv2) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            px1_reg   <= s_pixel_in;
            addr1_reg <= col_cur[AW-1:0];
            emit1_reg <= emit_cur;
            orow1_reg <= mf3_pkg::coord_t'(row_m1);
            ocol1_reg <= mf3_pkg::coord_t'(col_m1);
            byp1_reg  <= byp_next;
            bup1_reg  <= mid1;
            bmid1_reg <= px1_reg;
        end
        if (adv1) begin
            orow2_reg <= orow1_reg;
            ocol2_reg <= ocol1_reg;
        end
        if (adv2) begin
            m_median_reg <= median;
            m_row_reg    <= orow2_reg;
            m_col_reg    <= ocol2_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_median_value = m_median_reg;
    assign m_center_row   = m_row_reg;
    assign m_center_col   = m_col_reg;

endmodule
